### sv/i2c_master_register_access_assert.svh
// ----------------------------------------------------------------------------
// I2C master register access - assertion macros
// Shared concurrent assertion forms, clocked on i_clk, held off in reset.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_REGISTER_ACCESS_ASSERT_SVH
`define I2C_MASTER_REGISTER_ACCESS_ASSERT_SVH

// Same-cycle implication.
`define I2CM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define I2CM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### sv/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// I2C master register access - package
// Bus phases, byte kinds, request codes and the item/result layouts.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    typedef enum logic [4:0] {
        PH_IDLE = 5'd0,
        PH_PRE1 = 5'd1,
        PH_PRE2 = 5'd2,
        PH_STA  = 5'd3,
        PH_STB  = 5'd4,
        PH_TXH  = 5'd5,
        PH_TXL  = 5'd6,
        PH_ACKH = 5'd7,
        PH_ACKL = 5'd8,
        PH_LOAD = 5'd9,
        PH_RXH  = 5'd10,
        PH_RXL  = 5'd11,
        PH_MAH  = 5'd12,
        PH_MAL  = 5'd13,
        PH_SPP  = 5'd14,
        PH_SPA  = 5'd15,
        PH_SPB  = 5'd16
    } t_phase;

    typedef enum logic [1:0] {
        KIND_ADDR  = 2'd0,
        KIND_REG   = 2'd1,
        KIND_RADDR = 2'd2,
        KIND_DATA  = 2'd3
    } t_kind;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [15:0] HALF_PERIOD_RESET = 16'd250;
    localparam int unsigned ITEM_W   = 33;
    localparam int unsigned RESULT_W = 16;

    // Packed structs list the MSB first: dev_addr lands at bit 0.
    typedef struct packed {
        logic       sda_in;
        logic [7:0] wr_data;
        logic [7:0] byte_count;
        logic [7:0] reg_addr;
        logic [7:0] dev_addr;
    } t_item;

    // scl_out lands at bit 0.
    typedef struct packed {
        logic       status;
        logic       done_res;
        logic       busy_res;
        logic       rx_valid;
        logic [7:0] rx_data;
        logic       wr_data_req;
        logic       sda_drive;
        logic       sda_out;
        logic       scl_out;
    } t_result;

endpackage

### sv/i2cm_core.sv
// ----------------------------------------------------------------------------
// I2C master register access - bus sequencer
// Steps the bus sequencer once per accepted tick and forms its result.
// ----------------------------------------------------------------------------
`include "i2c_master_register_access_assert.svh"

module i2cm_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [1:0]       i_cmd,
    input  i2cm_pkg::t_item  i_item,
    input  logic [15:0]      i_half_period,
    output i2cm_pkg::t_result o_result
);

    i2cm_pkg::t_phase r_phase, n_phase, e_phase;
    i2cm_pkg::t_kind  r_kind, n_kind;
    logic [15:0] r_half_timer, n_half_timer;
    logic [3:0]  r_bit_index, n_bit_index;
    logic [7:0]  r_bytes_left, n_bytes_left;
    logic [7:0]  r_shift, n_shift;
    logic [7:0]  r_dev, n_dev;
    logic [7:0]  r_reg, n_reg;
    logic        r_read_mode, n_read_mode;
    logic        r_nack, n_nack;
    logic        r_restart, n_restart;

    logic        w_start;
    logic [15:0] w_limit;
    logic [3:0]  w_bit_inc;
    logic        v_req, v_rxv, v_done, v_status;
    logic [7:0]  v_rxd;
    logic        v_scl, v_sda, v_drv;

    assign w_start = (r_phase == i2cm_pkg::PH_IDLE) &&
                     (i_cmd == i2cm_pkg::CMD_WRITE || i_cmd == i2cm_pkg::CMD_READ);
    assign e_phase = w_start ? i2cm_pkg::PH_PRE1 : r_phase;
    assign w_limit = (i_half_period == 16'd0) ? 16'd1 : i_half_period;
    assign w_bit_inc = r_bit_index + 4'd1;

    // Next state and per-tick events
    always_comb begin
        n_phase      = r_phase;
        n_kind       = r_kind;
        n_half_timer = r_half_timer;
        n_bit_index  = r_bit_index;
        n_bytes_left = r_bytes_left;
        n_shift      = r_shift;
        n_dev        = r_dev;
        n_reg        = r_reg;
        n_read_mode  = r_read_mode;
        n_nack       = r_nack;
        n_restart    = r_restart;
        v_req        = 1'b0;
        v_rxv        = 1'b0;
        v_rxd        = 8'd0;
        v_done       = 1'b0;
        v_status     = 1'b0;

        if (w_start) begin
            n_dev        = i_item.dev_addr;
            n_reg        = i_item.reg_addr;
            n_bytes_left = i_item.byte_count;
            n_read_mode  = (i_cmd == i2cm_pkg::CMD_READ);
            n_nack       = 1'b0;
            n_restart    = 1'b0;
            n_kind       = i2cm_pkg::KIND_ADDR;
            n_bit_index  = 4'd0;
            n_shift      = 8'd0;
            n_half_timer = 16'd0;
            n_phase      = i2cm_pkg::PH_PRE1;
        end

        if (e_phase == i2cm_pkg::PH_LOAD) begin
            // one-tick load of the next write byte
            n_shift      = i_item.wr_data;
            n_bytes_left = r_bytes_left - 8'd1;
            n_kind       = i2cm_pkg::KIND_DATA;
            n_bit_index  = 4'd0;
            n_half_timer = 16'd0;
            n_phase      = i2cm_pkg::PH_TXH;
        end else if (e_phase != i2cm_pkg::PH_IDLE) begin
            n_half_timer = n_half_timer + 16'd1;
            if (n_half_timer >= w_limit) begin
                n_half_timer = 16'd0;
                unique case (e_phase)
                    i2cm_pkg::PH_PRE1: n_phase = i2cm_pkg::PH_PRE2;
                    i2cm_pkg::PH_PRE2: n_phase = i2cm_pkg::PH_STA;
                    i2cm_pkg::PH_STA:  n_phase = i2cm_pkg::PH_STB;
                    i2cm_pkg::PH_STB: begin
                        n_shift     = (r_kind == i2cm_pkg::KIND_RADDR) ?
                                      (r_dev | 8'h01) : r_dev;
                        n_bit_index = 4'd0;
                        n_phase     = i2cm_pkg::PH_TXH;
                    end
                    i2cm_pkg::PH_TXH:  n_phase = i2cm_pkg::PH_TXL;
                    i2cm_pkg::PH_TXL: begin
                        n_bit_index = w_bit_inc;
                        n_phase     = (w_bit_inc >= 4'd8) ? i2cm_pkg::PH_ACKH :
                                                            i2cm_pkg::PH_TXH;
                    end
                    i2cm_pkg::PH_ACKH: begin
                        n_nack  = i_item.sda_in;
                        n_phase = i2cm_pkg::PH_ACKL;
                    end
                    i2cm_pkg::PH_ACKL: begin
                        if (r_nack) begin
                            n_phase = i2cm_pkg::PH_SPP;
                        end else if (r_kind == i2cm_pkg::KIND_ADDR) begin
                            n_kind      = i2cm_pkg::KIND_REG;
                            n_shift     = r_reg;
                            n_bit_index = 4'd0;
                            n_phase     = i2cm_pkg::PH_TXH;
                        end else if (r_kind == i2cm_pkg::KIND_REG && r_read_mode) begin
                            n_restart = 1'b1;
                            n_phase   = i2cm_pkg::PH_SPP;
                        end else if (r_kind == i2cm_pkg::KIND_RADDR) begin
                            if (r_bytes_left != 8'd0) begin
                                n_bit_index = 4'd0;
                                n_shift     = 8'd0;
                                n_phase     = i2cm_pkg::PH_RXH;
                            end else begin
                                n_phase = i2cm_pkg::PH_SPP;
                            end
                        end else if (r_bytes_left != 8'd0) begin
                            v_req   = 1'b1;
                            n_phase = i2cm_pkg::PH_LOAD;
                        end else begin
                            n_phase = i2cm_pkg::PH_SPP;
                        end
                    end
                    i2cm_pkg::PH_RXH: begin
                        n_shift = {r_shift[6:0], i_item.sda_in};
                        n_phase = i2cm_pkg::PH_RXL;
                    end
                    i2cm_pkg::PH_RXL: begin
                        n_bit_index = w_bit_inc;
                        if (w_bit_inc >= 4'd8) begin
                            v_rxv        = 1'b1;
                            v_rxd        = r_shift;
                            n_bytes_left = r_bytes_left - 8'd1;
                            n_phase      = i2cm_pkg::PH_MAH;
                        end else begin
                            n_phase = i2cm_pkg::PH_RXH;
                        end
                    end
                    i2cm_pkg::PH_MAH:  n_phase = i2cm_pkg::PH_MAL;
                    i2cm_pkg::PH_MAL: begin
                        if (r_bytes_left != 8'd0) begin
                            n_bit_index = 4'd0;
                            n_shift     = 8'd0;
                            n_phase     = i2cm_pkg::PH_RXH;
                        end else begin
                            n_phase = i2cm_pkg::PH_SPP;
                        end
                    end
                    i2cm_pkg::PH_SPP:  n_phase = i2cm_pkg::PH_SPA;
                    i2cm_pkg::PH_SPA:  n_phase = i2cm_pkg::PH_SPB;
                    default: begin
                        if (r_restart && !r_nack) begin
                            n_restart = 1'b0;
                            n_kind    = i2cm_pkg::KIND_RADDR;
                            n_phase   = i2cm_pkg::PH_STA;
                        end else begin
                            v_done    = 1'b1;
                            v_status  = r_nack;
                            n_restart = 1'b0;
                            n_phase   = i2cm_pkg::PH_IDLE;
                        end
                    end
                endcase
            end
        end
    end

    // Bus levels of the current phase
    always_comb begin
        v_scl = 1'b1;
        v_sda = 1'b1;
        v_drv = 1'b1;
        unique case (e_phase)
            i2cm_pkg::PH_STA: begin
                v_sda = 1'b0;
            end
            i2cm_pkg::PH_STB, i2cm_pkg::PH_ACKL, i2cm_pkg::PH_LOAD,
            i2cm_pkg::PH_SPP: begin
                v_scl = 1'b0;
                v_sda = 1'b0;
            end
            i2cm_pkg::PH_TXH, i2cm_pkg::PH_TXL: begin
                v_scl = (e_phase == i2cm_pkg::PH_TXH);
                v_sda = r_shift[~r_bit_index[2:0]];
            end
            i2cm_pkg::PH_ACKH, i2cm_pkg::PH_RXH: begin
                v_sda = 1'b0;
                v_drv = 1'b0;
            end
            i2cm_pkg::PH_RXL: begin
                v_scl = 1'b0;
                v_sda = 1'b0;
                v_drv = 1'b0;
            end
            i2cm_pkg::PH_MAH, i2cm_pkg::PH_MAL: begin
                v_scl = (e_phase == i2cm_pkg::PH_MAH);
                v_sda = (r_bytes_left == 8'd0);
            end
            i2cm_pkg::PH_SPA: begin
                v_sda = 1'b0;
            end
            default: begin
                v_scl = 1'b1;
            end
        endcase

        o_result.scl_out     = v_scl;
        o_result.sda_out     = v_sda & v_drv;
        o_result.sda_drive   = v_drv;
        o_result.wr_data_req = v_req;
        o_result.rx_data     = v_rxd;
        o_result.rx_valid    = v_rxv;
        o_result.busy_res    = (e_phase != i2cm_pkg::PH_IDLE);
        o_result.done_res    = v_done;
        o_result.status      = v_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= i2cm_pkg::PH_IDLE;
            r_kind       <= i2cm_pkg::KIND_ADDR;
            r_half_timer <= 16'd0;
            r_bit_index  <= 4'd0;
            r_bytes_left <= 8'd0;
            r_read_mode  <= 1'b0;
            r_nack       <= 1'b0;
            r_restart    <= 1'b0;
        end else if (i_fire) begin
            r_phase      <= n_phase;
            r_kind       <= n_kind;
            r_half_timer <= n_half_timer;
            r_bit_index  <= n_bit_index;
            r_bytes_left <= n_bytes_left;
            r_read_mode  <= n_read_mode;
            r_nack       <= n_nack;
            r_restart    <= n_restart;
        end
    end

    // Byte and address holding registers, loaded at start before first use
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_shift <= n_shift;
            r_dev   <= n_dev;
            r_reg   <= n_reg;
        end
    end

    `I2CM_ASSERT_NEXT(a_req_then_load, i_fire && o_result.wr_data_req, r_phase == i2cm_pkg::PH_LOAD, "write data request not followed by load")
    `I2CM_ASSERT_NEXT(a_done_then_idle, i_fire && o_result.done_res, r_phase == i2cm_pkg::PH_IDLE, "done without return to idle")
    `I2CM_ASSERT_NOW(a_bit_range, 1'b1, r_bit_index <= 4'd8, "bit index beyond one byte")
    `I2CM_ASSERT_NOW(a_done_busy, o_result.done_res || o_result.rx_valid, o_result.busy_res, "event reported outside a transfer")

endmodule

### sv/i2cm_obuf.sv
// ----------------------------------------------------------------------------
// I2C master register access - result register
// Holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module i2cm_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  i2cm_pkg::t_result i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output i2cm_pkg::t_result o_data
);

    logic              r_valid;
    i2cm_pkg::t_result r_data;

    // Take a new item when empty or when the held one leaves this cycle.
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### sv/i2c_master_register_access.sv
// ----------------------------------------------------------------------------
// I2C master register access - top level
// Tick-driven I2C master for register writes and register reads.
// ----------------------------------------------------------------------------
// Usage:
//   Every item on the s_axis channel is one system tick. tuser carries the
//   request (plain tick, start register write, start register read); tdata
//   carries the device address, register address, byte count, the next
//   write byte and the sampled SDA level. Each accepted item yields exactly
//   one result item on m_axis: SCL/SDA levels, SDA drive enable, write data
//   request, received byte and transfer status.
//   Each result is registered in the output register; throughput is one item
//   per cycle while m_axis takes results. The phase sequencer updates
//   all its state in a single pass per item, and the output register lets a
//   new item enter while the previous result is still being taken.
//   When m_axis stalls, s_axis_tready drops once the output register is full
//   and the bus state holds until the result drains.
//   The half period register (cfg channel, reset 250 ticks) paces the bus;
//   write it only while no transfer is running.
//   Reset returns the sequencer to idle with the bus released high and
//   empties the output register.
// ----------------------------------------------------------------------------
module i2c_master_register_access (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: dev_addr[7:0], reg_addr[15:8], byte_count[23:16], wr_data[31:24],
    //        sda_in[32], zero fill[39:33]
    input  logic [39:0] s_axis_tdata,
    // tuser: cmd[1:0]
    input  logic [1:0]  s_axis_tuser,
    // result channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: scl_out[0], sda_out[1], sda_drive[2], wr_data_req[3],
    //        rx_data[11:4], rx_valid[12], busy_res[13], done_res[14], status[15]
    output logic [15:0] m_axis_tdata,
    // half period register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    logic              w_fire;
    i2cm_pkg::t_item   w_item;
    i2cm_pkg::t_result w_result;
    i2cm_pkg::t_result w_out;
    logic [15:0]       r_half_period;

    // Config is always accepted; software must write it only between transfers, a rule the block leaves to the user.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= i2cm_pkg::HALF_PERIOD_RESET;
        end else if (i_cfg_valid) begin
            r_half_period <= i_cfg_data;
        end
    end

    // Drop the zero fill bits of the request
    assign w_item = i2cm_pkg::t_item'(s_axis_tdata[i2cm_pkg::ITEM_W-1:0]);
    assign w_fire = s_axis_tvalid && s_axis_tready;

    i2cm_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (w_fire),
        .i_cmd         (s_axis_tuser),
        .i_item        (w_item),
        .i_half_period (r_half_period),
        .o_result      (w_result)
    );

    i2cm_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (w_result),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (w_out)
    );

    assign m_axis_tdata = w_out;

endmodule

### sim/i2c_master_register_access_tb.sv
// ----------------------------------------------------------------------------
// I2C master register access - testbench
// Streams system ticks into the master and answers the bus from a slave
// model that follows a shadow copy of the sequencer. It acknowledges or
// refuses bytes by plan and supplies random read data. Every result item
// is checked field by field against a tick-by-tick prediction.
// ----------------------------------------------------------------------------
module i2c_master_register_access_tb;

    // Request code that the block must treat as a plain tick.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // Sequencer state as the prediction tracks it.
    typedef struct packed {
        i2cm_pkg::t_phase ph;
        logic [15:0]      timer;
        logic [3:0]       bit_idx;
        logic [7:0]       left;
        logic [7:0]       shreg;
        logic [7:0]       dev;
        logic [7:0]       regb;
        logic             rd;
        logic             nack;
        i2cm_pkg::t_kind  kind;
        logic             restart;
    } t_bus_state;

    // One tick as it waits to be sent: request code plus the data fields.
    typedef struct packed {
        logic [1:0]      cmd;
        i2cm_pkg::t_item item;
    } t_tick;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        s_axis_tvalid  = 1'b0;
    logic        s_axis_tready;
    // tdata: dev_addr[7:0], reg_addr[15:8], byte_count[23:16], wr_data[31:24],
    //        sda_in[32], zero fill[39:33]
    logic [39:0] s_axis_tdata   = '0;
    // tuser: cmd[1:0]
    logic [1:0]  s_axis_tuser   = i2cm_pkg::CMD_TICK;
    logic        m_axis_tvalid;
    logic        m_axis_tready  = 1'b0;
    // tdata: scl_out[0], sda_out[1], sda_drive[2], wr_data_req[3],
    //        rx_data[11:4], rx_valid[12], busy_res[13], done_res[14], status[15]
    logic [15:0] m_axis_tdata;
    logic        i_cfg_valid    = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data     = '0;

    // Ticks waiting to be offered, and bus levels predicted for accepted ticks.
    t_tick             tick_q[$];
    i2cm_pkg::t_result bus_expect_q[$];
    // Slave answers for upcoming ACK slots: 0 acknowledges, 1 refuses.
    logic              ack_plan_q[$];

    // Prediction copy, updated on accepted ticks and register writes.
    t_bus_state  pred_state;
    logic [15:0] pred_hp;
    // Stimulus copy, stepped as ticks are queued so the slave knows the phase.
    t_bus_state  plan_state;
    logic [15:0] plan_hp;

    int                send_idle_pct  = 0;
    int                recv_stall_pct = 0;
    int                hold_left      = 0;
    int                fail_count     = 0;
    t_tick             offer;
    i2cm_pkg::t_result seen_res;
    i2cm_pkg::t_item   seen_item;

    i2c_master_register_access u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void bus_reset(output t_bus_state s);
        s.ph      = i2cm_pkg::PH_IDLE;
        s.timer   = '0;
        s.bit_idx = '0;
        s.left    = '0;
        s.shreg   = '0;
        s.dev     = '0;
        s.regb    = '0;
        s.rd      = 1'b0;
        s.nack    = 1'b0;
        s.kind    = i2cm_pkg::KIND_ADDR;
        s.restart = 1'b0;
    endfunction

    // Advance the sequencer by one system tick and return the bus levels and
    // flags of that tick.
    function automatic i2cm_pkg::t_result i2c_tick(inout t_bus_state s,
                                                   input logic [15:0] hp,
                                                   input logic [1:0] cmd,
                                                   input i2cm_pkg::t_item it);
        i2cm_pkg::t_result r;
        logic [15:0]       lim;
        logic              fin;
        r           = '0;
        r.scl_out   = 1'b1;
        r.sda_out   = 1'b1;
        r.sda_drive = 1'b1;
        // a zero half period paces like one tick
        lim = (hp == 16'd0) ? 16'd1 : hp;

        // latch a request only when idle; requests while busy are dropped
        if (s.ph == i2cm_pkg::PH_IDLE &&
            (cmd == i2cm_pkg::CMD_WRITE || cmd == i2cm_pkg::CMD_READ)) begin
            s.dev     = it.dev_addr;
            s.regb    = it.reg_addr;
            s.left    = it.byte_count;
            s.rd      = (cmd == i2cm_pkg::CMD_READ);
            s.nack    = 1'b0;
            s.restart = 1'b0;
            s.kind    = i2cm_pkg::KIND_ADDR;
            s.bit_idx = '0;
            s.shreg   = '0;
            s.timer   = '0;
            s.ph      = i2cm_pkg::PH_PRE1;
        end
        if (s.ph == i2cm_pkg::PH_IDLE)
            return r;
        r.busy_res = 1'b1;

        case (s.ph)
            i2cm_pkg::PH_STA, i2cm_pkg::PH_SPA: r.sda_out = 1'b0;
            i2cm_pkg::PH_STB, i2cm_pkg::PH_ACKL, i2cm_pkg::PH_LOAD,
            i2cm_pkg::PH_SPP: begin
                r.scl_out = 1'b0;
                r.sda_out = 1'b0;
            end
            i2cm_pkg::PH_TXH, i2cm_pkg::PH_TXL: begin
                r.scl_out = (s.ph == i2cm_pkg::PH_TXH);
                r.sda_out = s.shreg[3'd7 - s.bit_idx[2:0]];
            end
            i2cm_pkg::PH_ACKH, i2cm_pkg::PH_RXH: begin
                r.sda_out   = 1'b0;
                r.sda_drive = 1'b0;
            end
            i2cm_pkg::PH_RXL: begin
                r.scl_out   = 1'b0;
                r.sda_out   = 1'b0;
                r.sda_drive = 1'b0;
            end
            i2cm_pkg::PH_MAH, i2cm_pkg::PH_MAL: begin
                // master NACK on the last byte, ACK otherwise
                r.scl_out = (s.ph == i2cm_pkg::PH_MAH);
                r.sda_out = (s.left == 8'd0);
            end
            default: ;
        endcase

        // the data load takes a single tick; every other phase a half period
        if (s.ph == i2cm_pkg::PH_LOAD) begin
            s.shreg   = it.wr_data;
            s.left    = s.left - 8'd1;
            s.kind    = i2cm_pkg::KIND_DATA;
            s.bit_idx = '0;
            s.timer   = '0;
            s.ph      = i2cm_pkg::PH_TXH;
            fin       = 1'b0;
        end else begin
            s.timer = s.timer + 16'd1;
            fin     = (s.timer >= lim);
        end

        if (fin) begin
            s.timer = '0;
            case (s.ph)
                i2cm_pkg::PH_PRE1: s.ph = i2cm_pkg::PH_PRE2;
                i2cm_pkg::PH_PRE2: s.ph = i2cm_pkg::PH_STA;
                i2cm_pkg::PH_STA:  s.ph = i2cm_pkg::PH_STB;
                i2cm_pkg::PH_STB: begin
                    s.shreg   = (s.kind == i2cm_pkg::KIND_RADDR) ? (s.dev | 8'h01) : s.dev;
                    s.bit_idx = '0;
                    s.ph      = i2cm_pkg::PH_TXH;
                end
                i2cm_pkg::PH_TXH:  s.ph = i2cm_pkg::PH_TXL;
                i2cm_pkg::PH_TXL: begin
                    s.bit_idx = s.bit_idx + 4'd1;
                    s.ph      = (s.bit_idx >= 4'd8) ? i2cm_pkg::PH_ACKH : i2cm_pkg::PH_TXH;
                end
                i2cm_pkg::PH_ACKH: begin
                    s.nack = it.sda_in;
                    s.ph   = i2cm_pkg::PH_ACKL;
                end
                i2cm_pkg::PH_ACKL: begin
                    if (s.nack) begin
                        s.ph = i2cm_pkg::PH_SPP;
                    end else if (s.kind == i2cm_pkg::KIND_ADDR) begin
                        s.kind    = i2cm_pkg::KIND_REG;
                        s.shreg   = s.regb;
                        s.bit_idx = '0;
                        s.ph      = i2cm_pkg::PH_TXH;
                    end else if (s.kind == i2cm_pkg::KIND_REG && s.rd) begin
                        // stop, then restart with the read address
                        s.restart = 1'b1;
                        s.ph      = i2cm_pkg::PH_SPP;
                    end else if (s.kind == i2cm_pkg::KIND_RADDR) begin
                        if (s.left != 8'd0) begin
                            s.bit_idx = '0;
                            s.shreg   = '0;
                            s.ph      = i2cm_pkg::PH_RXH;
                        end else begin
                            s.ph = i2cm_pkg::PH_SPP;
                        end
                    end else if (s.left != 8'd0) begin
                        r.wr_data_req = 1'b1;
                        s.ph          = i2cm_pkg::PH_LOAD;
                    end else begin
                        s.ph = i2cm_pkg::PH_SPP;
                    end
                end
                i2cm_pkg::PH_RXH: begin
                    s.shreg = {s.shreg[6:0], it.sda_in};
                    s.ph    = i2cm_pkg::PH_RXL;
                end
                i2cm_pkg::PH_RXL: begin
                    s.bit_idx = s.bit_idx + 4'd1;
                    if (s.bit_idx >= 4'd8) begin
                        r.rx_valid = 1'b1;
                        r.rx_data  = s.shreg;
                        s.left     = s.left - 8'd1;
                        s.ph       = i2cm_pkg::PH_MAH;
                    end else begin
                        s.ph = i2cm_pkg::PH_RXH;
                    end
                end
                i2cm_pkg::PH_MAH:  s.ph = i2cm_pkg::PH_MAL;
                i2cm_pkg::PH_MAL: begin
                    if (s.left != 8'd0) begin
                        s.bit_idx = '0;
                        s.shreg   = '0;
                        s.ph      = i2cm_pkg::PH_RXH;
                    end else begin
                        s.ph = i2cm_pkg::PH_SPP;
                    end
                end
                i2cm_pkg::PH_SPP:  s.ph = i2cm_pkg::PH_SPA;
                i2cm_pkg::PH_SPA:  s.ph = i2cm_pkg::PH_SPB;
                default: begin
                    if (s.restart && !s.nack) begin
                        s.restart = 1'b0;
                        s.kind    = i2cm_pkg::KIND_RADDR;
                        s.ph      = i2cm_pkg::PH_STA;
                    end else begin
                        r.done_res = 1'b1;
                        r.status   = s.nack;
                        s.restart  = 1'b0;
                        s.ph       = i2cm_pkg::PH_IDLE;
                    end
                end
            endcase
        end
        return r;
    endfunction

    // Queue one tick. The slave answers an ACK slot on its last tick, from
    // the plan if one is pending, else acknowledging.
    task automatic push_tick(input logic [1:0] cmd, input logic [7:0] dev,
                             input logic [7:0] rg, input logic [7:0] cnt);
        t_tick       tk;
        logic [15:0] lim;
        lim                = (plan_hp == 16'd0) ? 16'd1 : plan_hp;
        tk.cmd             = cmd;
        tk.item.dev_addr   = dev;
        tk.item.reg_addr   = rg;
        tk.item.byte_count = cnt;
        tk.item.wr_data    = 8'($urandom_range(255));
        tk.item.sda_in     = 1'($urandom_range(1));
        if (plan_state.ph == i2cm_pkg::PH_ACKH &&
            ({1'b0, plan_state.timer} + 17'd1 >= {1'b0, lim})) begin
            if (ack_plan_q.size() != 0)
                tk.item.sda_in = ack_plan_q.pop_front();
            else
                tk.item.sda_in = 1'b0;
        end
        void'(i2c_tick(plan_state, plan_hp, cmd, tk.item));
        tick_q.push_back(tk);
    endtask

    task automatic push_noise(input logic [1:0] cmd);
        push_tick(cmd, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)));
    endtask

    // Tick until the bus is idle again; noise_pct percent of the busy ticks
    // carry a random request code, which the block must ignore.
    task automatic tick_until_idle(input int noise_pct);
        logic [1:0] c;
        while (plan_state.ph != i2cm_pkg::PH_IDLE) begin
            c = i2cm_pkg::CMD_TICK;
            if ($urandom_range(99) < noise_pct)
                c = 2'($urandom_range(3));
            push_noise(c);
        end
    endtask

    // Issue one request and tick until the bus is idle again.
    task automatic run_transfer(input logic [1:0] cmd, input logic [7:0] dev,
                                input logic [7:0] rg, input logic [7:0] cnt,
                                input int noise_pct);
        push_tick(cmd, dev, rg, cnt);
        tick_until_idle(noise_pct);
    endtask

    // Write the half period register; only call while the bus is idle.
    task automatic set_half_period(input logic [15:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        pred_hp = v;
        plan_hp = v;
        @(negedge i_clk);
    endtask

    // Hold until every queued tick is sent and every result is back, then
    // let the output stage settle.
    task automatic wait_drained;
        while (tick_q.size() != 0 || s_axis_tvalid || bus_expect_q.size() != 0)
            @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic flag_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
        fail_count++;
        $display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    endtask

    task automatic check_result(input i2cm_pkg::t_result got);
        i2cm_pkg::t_result want;
        if (bus_expect_q.size() == 0) begin
            flag_mismatch("unexpected result item", got[7:0], 8'h00);
            return;
        end
        want = bus_expect_q.pop_front();
        if (got.scl_out !== want.scl_out)
            flag_mismatch("scl_out", 8'(got.scl_out), 8'(want.scl_out));
        if (got.sda_out !== want.sda_out)
            flag_mismatch("sda_out", 8'(got.sda_out), 8'(want.sda_out));
        if (got.sda_drive !== want.sda_drive)
            flag_mismatch("sda_drive", 8'(got.sda_drive), 8'(want.sda_drive));
        if (got.wr_data_req !== want.wr_data_req)
            flag_mismatch("wr_data_req", 8'(got.wr_data_req), 8'(want.wr_data_req));
        if (got.rx_data !== want.rx_data)
            flag_mismatch("rx_data", got.rx_data, want.rx_data);
        if (got.rx_valid !== want.rx_valid)
            flag_mismatch("rx_valid", 8'(got.rx_valid), 8'(want.rx_valid));
        if (got.busy_res !== want.busy_res)
            flag_mismatch("busy_res", 8'(got.busy_res), 8'(want.busy_res));
        if (got.done_res !== want.done_res)
            flag_mismatch("done_res", 8'(got.done_res), 8'(want.done_res));
        if (got.status !== want.status)
            flag_mismatch("status", 8'(got.status), 8'(want.status));
    endtask

    // Request side: offer the next queued tick whenever the slot is free,
    // skipping cycles at random; hold the offer until it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                offer = tick_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {7'b0, offer.item};
                s_axis_tuser  <= offer.cmd;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Count down a long receiver hold-off.
    always @(posedge i_clk) begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Result side: check the result taken at this edge first, then predict
    // for the tick taken at this edge, then pick the next ready level.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                seen_res = m_axis_tdata;
                check_result(seen_res);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                seen_item = s_axis_tdata[32:0];
                bus_expect_q.push_back(i2c_tick(pred_state, pred_hp, s_axis_tuser, seen_item));
            end
            m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        bus_reset(pred_state);
        bus_reset(plan_state);
        pred_hp = i2cm_pkg::HALF_PERIOD_RESET;
        plan_hp = i2cm_pkg::HALF_PERIOD_RESET;

        // Reset pacing: start a write with the default half period and hold
        // the first phase for a few ticks; the device address is refused.
        ack_plan_q.push_back(1'b1);
        push_tick(i2cm_pkg::CMD_WRITE, 8'h80, 8'h01, 8'd2);
        repeat (3) push_tick(i2cm_pkg::CMD_TICK, 8'h00, 8'h00, 8'h00);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait_drained();

        // Directed cases with a zero half period, which paces like one tick.
        set_half_period(16'd0);
        tick_until_idle(0);
        push_tick(CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF);
        push_tick(i2cm_pkg::CMD_TICK, 8'h00, 8'h00, 8'h00);
        // data byte refused, with stray requests while busy
        ack_plan_q.push_back(1'b0);
        ack_plan_q.push_back(1'b0);
        ack_plan_q.push_back(1'b1);
        run_transfer(i2cm_pkg::CMD_WRITE, 8'h5A, 8'hA5, 8'd1, 50);
        // two byte read: master ACK, then NACK on the last byte
        run_transfer(i2cm_pkg::CMD_READ, 8'h3C, 8'hC3, 8'd2, 0);
        // register byte refused during a read
        ack_plan_q.push_back(1'b0);
        ack_plan_q.push_back(1'b1);
        run_transfer(i2cm_pkg::CMD_READ, 8'h7E, 8'h81, 8'd2, 0);
        wait_drained();

        // One write with a data byte, sender idling.
        set_half_period(16'd1);
        send_idle_pct = 66;
        run_transfer(i2cm_pkg::CMD_WRITE, 8'hA0, 8'h10, 8'd1, 5);
        wait_drained();

        // Receiver stalling, with a long hold-off while the sender keeps
        // offering, so the output stage fills and back-pressures. A read
        // with no data bytes: restart, read address, stop.
        set_half_period(16'd0);
        send_idle_pct  = 0;
        recv_stall_pct = 66;
        run_transfer(i2cm_pkg::CMD_READ, 8'hA1, 8'h10, 8'd0, 5);
        hold_left = 300;
        wait_drained();

        // Both sides idling, two ticks per half period; device address refused.
        set_half_period(16'd2);
        send_idle_pct  = 35;
        recv_stall_pct = 35;
        ack_plan_q.push_back(1'b1);
        run_transfer(i2cm_pkg::CMD_WRITE, 8'hC8, 8'h3F, 8'd1, 5);
        wait_drained();

        if (fail_count == 0)
            $display("i2c_master_register_access_tb passed");
        else
            $display("i2c_master_register_access_tb failed");
        $finish;
    end

    // Guard against a hang.
    initial begin
        #200_000;
        $display("i2c_master_register_access_tb failed");
        $finish;
    end

endmodule
